FILE: rtl/core/ocrs_pkg.sv
`timescale 1ns / 1ps

package ocrs_pkg;

    // Default build of the block.
    localparam int DEF_BRANCH_LOG2  = 3;
    localparam int DEF_KEY_BITS     = 64;
    localparam int DEF_KEY_CAPACITY = 1024;
    localparam int DEF_QUEUE_DEPTH  = 2;

    // Fixed field widths of the ports.
    localparam int LOAD_IDX_W = 10;
    localparam int KEY_W      = 64;
    localparam int RANGE_W    = 11;
    localparam int DEPTH_W    = 5;
    localparam int NUM_W      = 4;
    localparam int SHIFT_W    = 6;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_SPLIT = 1'b1
    } t_action;

    // One classified command passed from the front end to the search engine.
    typedef struct packed {
        logic                  is_load;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [KEY_W-1:0]      key;
        logic [RANGE_W-1:0]    range_start;
        logic [RANGE_W-1:0]    range_end;
        logic [SHIFT_W-1:0]    shift;
    } t_cmd;

endpackage

FILE: rtl/core/ocrs_front.sv
`timescale 1ns / 1ps

module ocrs_front
    import ocrs_pkg::*;
#(
    parameter int BRANCH_LOG2  = DEF_BRANCH_LOG2,
    parameter int KEY_BITS     = DEF_KEY_BITS,
    parameter int KEY_CAPACITY = DEF_KEY_CAPACITY
) (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [LOAD_IDX_W-1:0] i_load_index,
    input  logic [KEY_W-1:0]      i_key_value,
    input  logic [RANGE_W-1:0]    i_range_start,
    input  logic [RANGE_W-1:0]    i_range_end,
    input  logic [KEY_W-1:0]      i_child_key,
    input  logic [DEPTH_W-1:0]    i_child_depth,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    localparam int CAP_CLIP  = (KEY_CAPACITY > 2047) ? 2047 : KEY_CAPACITY;
    localparam int LOAD_LIM  = (KEY_CAPACITY > 1024) ? 1024 : KEY_CAPACITY;
    localparam logic [RANGE_W-1:0] CAP_R    = RANGE_W'(CAP_CLIP);
    localparam logic [RANGE_W-1:0] LOAD_LIM_R = RANGE_W'(LOAD_LIM);
    localparam logic [7:0] LOG8 = 8'(BRANCH_LOG2);
    localparam logic [7:0] KB8  = 8'(KEY_BITS);

    logic [RANGE_W-1:0] start_sat;
    logic [RANGE_W-1:0] end_sat;
    logic [7:0]         used_bits;
    logic               is_split;
    logic               load_ok;

    always_comb begin
        start_sat = (i_range_start > CAP_R) ? CAP_R : i_range_start;
        end_sat   = (i_range_end > CAP_R) ? CAP_R : i_range_end;
        used_bits = 8'(LOG8 * {3'b000, i_child_depth}) + 8'd1;
        is_split  = (i_action == ACT_SPLIT);
        load_ok   = ({1'b0, i_load_index} < LOAD_LIM_R);
    end

    always_comb begin
        o_cmd.is_load     = !is_split;
        o_cmd.load_index  = i_load_index;
        o_cmd.key         = is_split ? i_child_key : i_key_value;
        o_cmd.range_end   = end_sat;
        o_cmd.range_start = (start_sat > end_sat) ? end_sat : start_sat;
        o_cmd.shift       = (used_bits > KB8) ? '0 : SHIFT_W'(KB8 - used_bits);
    end

    assign o_ready = !i_q_full;
    // Loads that fall outside the store are dropped here.
    assign o_push  = i_valid && o_ready && (is_split || load_ok);

endmodule

FILE: rtl/core/ocrs_queue.sv
`timescale 1ns / 1ps

module ocrs_queue
    import ocrs_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

    t_cmd            r_slots [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/ocrs_back.sv
`timescale 1ns / 1ps

module ocrs_back
    import ocrs_pkg::*;
#(
    parameter int BRANCH_LOG2  = DEF_BRANCH_LOG2,
    parameter int KEY_BITS     = DEF_KEY_BITS,
    parameter int KEY_CAPACITY = DEF_KEY_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [RANGE_W-1:0] o_splitter,
    output logic [NUM_W-1:0]   o_child_number,
    output logic               o_last
);

    localparam int AW     = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
    localparam int FANOUT = 1 << BRANCH_LOG2;
    localparam int CW     = BRANCH_LOG2 + 1;
    localparam logic [CW-1:0] CHILD_LAST = CW'(FANOUT);
    localparam logic [CW-1:0] CHILD_PRE  = CW'(FANOUT - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EMIT = 4'b0010,
        S_TEST = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    function automatic logic [RANGE_W-1:0] mid_of(input logic [RANGE_W-1:0] lo,
                                                  input logic [RANGE_W-1:0] hi);
        logic [RANGE_W-1:0] span;
        span = hi - lo;
        return lo + (span >> 1);
    endfunction

    logic [KEY_BITS-1:0] r_key_store [KEY_CAPACITY];

    t_state              r_state, n_state;
    logic [RANGE_W-1:0]  r_lo, n_lo;
    logic [RANGE_W-1:0]  r_hi, n_hi;
    logic [RANGE_W-1:0]  r_end, n_end;
    logic [RANGE_W-1:0]  r_mid, n_mid;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [KEY_BITS-1:0] r_test, n_test;
    logic [SHIFT_W-1:0]  r_shift, n_shift;
    logic [CW-1:0]       r_child, n_child;
    logic [KEY_BITS-1:0] r_rd_data;
    logic                r_out_valid, n_out_valid;
    logic [RANGE_W-1:0]  r_out_split;
    logic [NUM_W-1:0]    r_out_num;
    logic                r_out_last;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic               out_load;
    logic               out_free;
    logic               key_ge;
    logic [RANGE_W-1:0] cmp_lo;
    logic [RANGE_W-1:0] cmp_hi;
    logic [RANGE_W-1:0] cmp_mid;
    logic [RANGE_W-1:0] first_mid;

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_end     = r_end;
        n_mid     = r_mid;
        n_key     = r_key;
        n_test    = r_test;
        n_shift   = r_shift;
        n_child   = r_child;
        o_pop     = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        out_load  = 1'b0;
        out_free  = !r_out_valid || i_ready;
        key_ge    = (r_rd_data >= r_test);
        cmp_lo    = key_ge ? r_lo : r_mid + 1'b1;
        cmp_hi    = key_ge ? r_mid : r_hi;
        cmp_mid   = mid_of(cmp_lo, cmp_hi);
        first_mid = mid_of(r_lo, r_end);

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_load) begin
                        wr_en = 1'b1;
                    end else begin
                        n_lo    = i_cmd.range_start;
                        n_end   = i_cmd.range_end;
                        n_key   = i_cmd.key[KEY_BITS-1:0];
                        n_shift = i_cmd.shift;
                        n_child = '0;
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (r_child == CHILD_LAST) begin
                        n_state = S_IDLE;
                    end else if (r_child == CHILD_PRE) begin
                        n_child = CHILD_LAST;
                    end else begin
                        n_child = r_child + 1'b1;
                        n_key   = r_key + 1'b1;
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                n_test = r_key << r_shift;
                if (r_lo < r_end) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(first_mid);
                    n_mid   = first_mid;
                    n_hi    = r_end;
                    n_state = S_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CMP: begin
                n_lo = cmp_lo;
                n_hi = cmp_hi;
                if (cmp_lo < cmp_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(cmp_mid);
                    n_mid   = cmp_mid;
                end else begin
                    n_state = S_EMIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_end   <= n_end;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_test  <= n_test;
        r_shift <= n_shift;
        r_child <= n_child;
        if (out_load) begin
            r_out_split <= (r_child == CHILD_LAST) ? r_end : r_lo;
            r_out_num   <= NUM_W'(r_child);
            r_out_last  <= (r_child == CHILD_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_store[AW'(i_cmd.load_index)] <= i_cmd.key[KEY_BITS-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_key_store[rd_addr];
        end
    end

    assign o_valid        = r_out_valid;
    assign o_splitter     = r_out_split;
    assign o_child_number = r_out_num;
    assign o_last         = r_out_last;

endmodule

FILE: rtl/core/octree_child_range_splitter.sv
// Octree child range splitter. Load beats (action 0) write one sorted key into the key
// store and produce no output; a load whose index lies beyond the store is dropped. A
// split beat (action 1) returns 2^BRANCH_LOG2 + 1 output beats in order: the range
// start, one splitter per inner child found by a lower-bound binary search starting from
// the previous splitter, and the range end with last set. Store entries must be written
// before any split reads them; the store has no reset. Input beats are classified and
// queued by the front end, so new beats are taken while a split is still being searched,
// until the queue is full. The search engine writes a load into the store from its idle
// state, which stays ready for the next queued beat. The search time of a split is set
// by the single read port of the key store, which delivers one probe per cycle to the
// search loop. Output back-pressure holds the engine in its emit state until the output
// register is free.
`timescale 1ns / 1ps

module octree_child_range_splitter
    import ocrs_pkg::*;
#(
    parameter int BRANCH_LOG2  = DEF_BRANCH_LOG2,
    parameter int KEY_BITS     = DEF_KEY_BITS,
    parameter int KEY_CAPACITY = DEF_KEY_CAPACITY,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic [LOAD_IDX_W-1:0] i_load_index,
    input  logic [KEY_W-1:0]      i_key_value,
    input  logic [RANGE_W-1:0]    i_range_start,
    input  logic [RANGE_W-1:0]    i_range_end,
    input  logic [KEY_W-1:0]      i_child_key,
    input  logic [DEPTH_W-1:0]    i_child_depth,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [RANGE_W-1:0]    o_splitter,
    output logic [NUM_W-1:0]      o_child_number,
    output logic                  o_last
);

    // Between front end and search engine: one queued command per beat that needs work.
    logic q_full;
    logic q_push;
    t_cmd q_cmd_in;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd_out;

    // The front end saturates the range, folds an inverted range onto its end and works
    // out the shift that turns a child key into its lowest store key.
    ocrs_front #(
        .BRANCH_LOG2  (BRANCH_LOG2),
        .KEY_BITS     (KEY_BITS),
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_load_index  (i_load_index),
        .i_key_value   (i_key_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_child_key   (i_child_key),
        .i_child_depth (i_child_depth),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_cmd_in)
    );

    ocrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd_out)
    );

    // The search engine owns the key store, so loads and searches stay in beat order.
    // Its output register lets the next probe run while a splitter waits to be taken.
    ocrs_back #(
        .BRANCH_LOG2  (BRANCH_LOG2),
        .KEY_BITS     (KEY_BITS),
        .KEY_CAPACITY (KEY_CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_cmd          (q_cmd_out),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_splitter     (o_splitter),
        .o_child_number (o_child_number),
        .o_last         (o_last)
    );

endmodule

FILE: rtl/core/ocrs_checker.sv
`timescale 1ns / 1ps

module ocrs_checker
    import ocrs_pkg::*;
#(
    parameter int BRANCH_LOG2 = DEF_BRANCH_LOG2
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [RANGE_W-1:0] o_splitter,
    input logic [NUM_W-1:0]   o_child_number,
    input logic               o_last
);

    localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(1 << BRANCH_LOG2);

    logic               out_acc;
    logic [NUM_W-1:0]   r_exp_num;
    logic [RANGE_W-1:0] r_prev_split;

    assign out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_num    <= '0;
            r_prev_split <= '0;
        end else if (out_acc) begin
            r_exp_num    <= o_last ? '0 : o_child_number + 1'b1;
            r_prev_split <= o_splitter;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_splitter)
            && $stable(o_child_number) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_numbering: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_child_number == r_exp_num)
        else $error("child numbers out of sequence");

    a_last_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_last |-> o_child_number == LAST_NUM)
        else $error("last flag on wrong child number");

    a_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_exp_num != '0 |-> o_splitter >= r_prev_split)
        else $error("splitters not ascending");

endmodule

bind octree_child_range_splitter ocrs_checker #(
    .BRANCH_LOG2 (BRANCH_LOG2)
) u_ocrs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_splitter     (o_splitter),
    .o_child_number (o_child_number),
    .o_last         (o_last)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the octree child range splitter.
// Load beats fill a local copy of the key store. Each accepted split beat is expanded
// here into its nine splitters by an independent lower-bound search over that copy, and
// the splitters are queued. A checker pops the queue on every output beat and compares
// all fields. The bench never lets a search probe a store entry that has not been written.
// It tracks which entries hold a key and keeps every non-empty range inside written runs.
module tb;
    import ocrs_pkg::*;

    localparam int          BRANCH        = 1 << DEF_BRANCH_LOG2;
    localparam int          KEY_CAP       = DEF_KEY_CAPACITY;
    localparam int          RANGE_MAX     = (1 << RANGE_W) - 1;
    localparam int          RX_HOLD       = 500;
    localparam int          SETTLE_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int          REPORT_MAX    = 10;

    typedef struct {
        t_action               action;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [KEY_W-1:0]      key_value;
        logic [RANGE_W-1:0]    range_start;
        logic [RANGE_W-1:0]    range_end;
        logic [KEY_W-1:0]      child_key;
        logic [DEPTH_W-1:0]    child_depth;
    } t_op_beat;

    typedef struct packed {
        logic [RANGE_W-1:0] splitter;
        logic [NUM_W-1:0]   child_number;
        logic               last;
    } t_splitter;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic [LOAD_IDX_W-1:0] i_load_index;
    logic [KEY_W-1:0]      i_key_value;
    logic [RANGE_W-1:0]    i_range_start;
    logic [RANGE_W-1:0]    i_range_end;
    logic [KEY_W-1:0]      i_child_key;
    logic [DEPTH_W-1:0]    i_child_depth;
    logic                  o_valid;
    logic                  i_ready;
    logic [RANGE_W-1:0]    o_splitter;
    logic [NUM_W-1:0]      o_child_number;
    logic                  o_last;

    // Local image of the key store and a record of which entries hold a key.
    logic [KEY_W-1:0] key_mem [KEY_CAP];
    bit               key_written [KEY_CAP];

    t_splitter   splitter_q [$];
    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    int unsigned cycle_count    = 0;

    // Shared with the receiver process: calm switches random idling off on both sides.
    bit calm         = 1'b0;
    bit rx_hold_req  = 1'b0;
    bit rx_hold_done = 1'b0;

    octree_child_range_splitter DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_load_index   (i_load_index),
        .i_key_value    (i_key_value),
        .i_range_start  (i_range_start),
        .i_range_end    (i_range_end),
        .i_child_key    (i_child_key),
        .i_child_depth  (i_child_depth),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_splitter     (o_splitter),
        .o_child_number (o_child_number),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d splitters outstanding",
                     cycle_count, splitter_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Shift that places a child key at its depth. Deeper than the key can hold, the shift
    // saturates at zero.
    function automatic int unsigned depth_shift(input logic [DEPTH_W-1:0] depth);
        int unsigned used;
        used = DEF_BRANCH_LOG2 * depth + 1;
        return (used > KEY_W) ? 0 : KEY_W - used;
    endfunction

    // Applies one accepted beat: a load updates the store image, a split queues its
    // splitters.
    function automatic void predict_splitters(input t_op_beat b);
        int unsigned      lo, hi, bound, mid, sh, child;
        logic [KEY_W-1:0] key, probe;
        if (b.action == ACT_LOAD) begin
            if (b.load_index < KEY_CAP) begin
                key_mem[b.load_index] = b.key_value;
            end
            return;
        end
        lo = (b.range_start > KEY_CAP) ? KEY_CAP : b.range_start;
        hi = (b.range_end > KEY_CAP) ? KEY_CAP : b.range_end;
        if (lo > hi) begin
            lo = hi;
        end
        sh  = depth_shift(b.child_depth);
        key = b.child_key;
        splitter_q.push_back('{RANGE_W'(lo), NUM_W'(0), 1'b0});
        for (child = 1; child < BRANCH; child++) begin
            key   = key + 1'b1;
            probe = key << sh;
            bound = hi;
            // Lower bound: the first entry in [lo, bound) whose key is not below the probe.
            while (lo < bound) begin
                mid = lo + ((bound - lo) >> 1);
                if (key_mem[mid] >= probe) begin
                    bound = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            splitter_q.push_back('{RANGE_W'(lo), NUM_W'(child), 1'b0});
        end
        splitter_q.push_back('{RANGE_W'(hi), NUM_W'(BRANCH), 1'b1});
    endfunction

    // Fields a beat does not use still carry random values.
    function automatic t_op_beat load_beat(input int unsigned idx, input logic [KEY_W-1:0] key);
        t_op_beat b;
        b.action      = ACT_LOAD;
        b.load_index  = LOAD_IDX_W'(idx);
        b.key_value   = key;
        b.range_start = RANGE_W'($urandom);
        b.range_end   = RANGE_W'($urandom);
        b.child_key   = {$urandom, $urandom};
        b.child_depth = DEPTH_W'($urandom);
        key_written[idx % KEY_CAP] = 1'b1;
        return b;
    endfunction

    function automatic t_op_beat split_beat(input int unsigned rs, input int unsigned re,
                                            input logic [KEY_W-1:0] ck,
                                            input logic [DEPTH_W-1:0] depth);
        t_op_beat b;
        b.action      = ACT_SPLIT;
        b.load_index  = LOAD_IDX_W'($urandom);
        b.key_value   = {$urandom, $urandom};
        b.range_start = RANGE_W'(rs);
        b.range_end   = RANGE_W'(re);
        b.child_key   = ck;
        b.child_depth = depth;
        return b;
    endfunction

    // Most child keys are taken from a stored key in the range, so that the children
    // really cut it; the rest are arbitrary. Depths beyond the key width turn up too.
    task automatic pick_child(input int unsigned lo, input int unsigned hi,
                              output logic [KEY_W-1:0] ck, output logic [DEPTH_W-1:0] depth);
        int unsigned sh;
        depth = ($urandom_range(0, 99) < 12) ? DEPTH_W'($urandom_range(22, 31))
                                             : DEPTH_W'($urandom_range(0, 21));
        sh    = depth_shift(depth);
        if (hi > lo && $urandom_range(0, 99) < 70) begin
            ck = (key_mem[$urandom_range(lo, hi - 1)] >> sh) - KEY_W'($urandom_range(0, 6));
        end else begin
            ck = {$urandom, $urandom};
        end
    endtask

    // A range that probes only written entries. Now and then it is empty, inverted or
    // beyond the store, in which case nothing is probed at all.
    task automatic make_random_split(output t_op_beat b);
        int unsigned      s, stop, n, re, lo, hi;
        logic [KEY_W-1:0]   ck;
        logic [DEPTH_W-1:0] depth;
        if ($urandom_range(0, 99) < 15) begin
            s  = $urandom_range(0, RANGE_MAX);
            re = $urandom_range(0, s);
        end else begin
            s = $urandom_range(0, KEY_CAP - 1);
            n = 0;
            while (!key_written[s] && n < KEY_CAP) begin
                s = (s + 1) % KEY_CAP;
                n++;
            end
            stop = s;
            while (stop < KEY_CAP && key_written[stop]) begin
                stop++;
            end
            if ($urandom_range(0, 99) < 10) begin
                re = stop;
            end else begin
                re = s + 1 + $urandom_range(0, (stop - s - 1 > 31) ? 31 : stop - s - 1);
            end
            if (re == KEY_CAP && $urandom_range(0, 1) == 1) begin
                re = $urandom_range(KEY_CAP, RANGE_MAX);
            end
        end
        lo = (s > KEY_CAP) ? KEY_CAP : s;
        hi = (re > KEY_CAP) ? KEY_CAP : re;
        pick_child(lo, (hi > lo) ? hi : lo, ck, depth);
        b = split_beat(s, re, ck, depth);
    endtask

    // Offers one beat from a falling edge and returns just after the edge that takes it.
    // Valid stays high into the next call unless an idle cycle comes first.
    task automatic send_beat(input t_op_beat b);
        while (!calm && $urandom_range(0, 99) < 9) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_action      <= b.action;
        i_load_index  <= b.load_index;
        i_key_value   <= b.key_value;
        i_range_start <= b.range_start;
        i_range_end   <= b.range_end;
        i_child_key   <= b.child_key;
        i_child_depth <= b.child_depth;
        forever begin
            @(posedge i_clk);
            if (o_ready) begin
                break;
            end
        end
        predict_splitters(b);
        beats_sent++;
    endtask

    // Receiver: random stalls, or one long hold-off counted here when asked for.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !rx_hold_done) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD - 1) @(negedge i_clk);
                rx_hold_done = 1'b1;
            end else begin
                i_ready <= calm || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    task automatic note_mismatch(input string what, input t_splitter exp_s,
                                 input t_splitter got_s);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] %s: expected splitter %0d child %0d last %0b, got %0d %0d %0b",
                     $realtime, what, exp_s.splitter, exp_s.child_number, exp_s.last,
                     got_s.splitter, got_s.child_number, got_s.last);
        end
    endtask

    // Output checker: every output beat is compared with the oldest expected splitter.
    always @(posedge i_clk) begin
        t_splitter got_s, exp_s;
        if (i_rst_n && o_valid && i_ready) begin
            got_s = '{o_splitter, o_child_number, o_last};
            if (splitter_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, got_s);
            end else begin
                exp_s = splitter_q.pop_front();
                if (got_s !== exp_s) begin
                    note_mismatch("splitter mismatch", exp_s, got_s);
                end
            end
        end
    end

    // Directed corners: index and key extremes, increment wrap, saturated, inverted and
    // empty ranges, a single-entry range and depths past the key width.
    task automatic test_corner_splits();
        send_beat(load_beat(0, 64'h0));
        send_beat(load_beat(1, 64'h2000_0000_0000_0000));
        send_beat(load_beat(2, 64'h8000_0000_0000_0000));
        send_beat(load_beat(3, 64'hFFFF_FFFF_FFFF_FFFF));
        send_beat(load_beat(1020, 64'hFFFF_FFFF_FFFF_FFF9));
        send_beat(load_beat(1021, 64'hFFFF_FFFF_FFFF_FFFB));
        send_beat(load_beat(1022, 64'hFFFF_FFFF_FFFF_FFFD));
        send_beat(load_beat(1023, 64'hFFFF_FFFF_FFFF_FFFF));
        send_beat(split_beat(0, 4, 64'h0, 5'd0));
        send_beat(split_beat(0, 4, 64'h1, 5'd1));
        // Child keys wrap through zero; the range end saturates to the store size.
        send_beat(split_beat(1020, RANGE_MAX, 64'hFFFF_FFFF_FFFF_FFFA, 5'd21));
        send_beat(split_beat(RANGE_MAX, RANGE_MAX, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31));
        send_beat(split_beat(600, 2, 64'h0, 5'd22));
        send_beat(split_beat(0, 0, 64'h0, 5'd0));
        send_beat(split_beat(3, 4, 64'hFFFF_FFFF_FFFF_FFFE, 5'd21));
        send_beat(split_beat(0, 4, {$urandom, $urandom}, 5'd25));
        send_beat(split_beat(1023, KEY_CAP, 64'h3FF, 5'd10));
    endtask

    // Mostly runs of ascending keys followed by splits over them, with stray loads and
    // arbitrary splits mixed in.
    task automatic test_random_runs(input int unsigned count);
        int unsigned      first, base, len, scale, j, nsplit, lo, hi;
        logic [KEY_W-1:0]   k, ck;
        logic [DEPTH_W-1:0] depth;
        t_op_beat         b;
        first = beats_sent;
        while (beats_sent - first < count) begin
            j = $urandom_range(0, 99);
            if (j < 70) begin
                base  = $urandom_range(0, KEY_CAP - 1);
                len   = $urandom_range(2, 24);
                len   = (base + len > KEY_CAP) ? KEY_CAP - base : len;
                scale = $urandom_range(0, 56);
                k     = {$urandom, $urandom} >> $urandom_range(1, 8);
                for (j = 0; j < len; j++) begin
                    send_beat(load_beat(base + j, k));
                    k = k + ({$urandom, $urandom} >> (63 - scale)) + 1'b1;
                end
                nsplit = $urandom_range(1, 4);
                for (j = 0; j < nsplit; j++) begin
                    lo = base + $urandom_range(0, len - 1);
                    hi = $urandom_range(lo + 1, base + len);
                    pick_child(lo, hi, ck, depth);
                    send_beat(split_beat(lo, hi, ck, depth));
                end
            end else if (j < 85) begin
                send_beat(load_beat($urandom_range(0, KEY_CAP - 1), {$urandom, $urandom}));
            end else begin
                make_random_split(b);
                send_beat(b);
            end
        end
    endtask

    // The receiver holds off while splits keep coming, so the block fills and stalls its
    // input. Afterwards the sender drops valid and waits for every splitter before it
    // goes on.
    task automatic test_output_stall();
        t_op_beat b;
        int       j;
        rx_hold_req = 1'b1;
        for (j = 0; j < 12; j++) begin
            make_random_split(b);
            send_beat(b);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (!rx_hold_done) begin
            @(posedge i_clk);
        end
        while (splitter_q.size() != 0) begin
            @(posedge i_clk);
        end
        for (j = 0; j < 4; j++) begin
            make_random_split(b);
            send_beat(b);
        end
    endtask

    // A stretch with no idling on either side, beats back to back.
    task automatic test_back_to_back();
        calm = 1'b1;
        test_random_runs(60);
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_LOAD;
        i_load_index  = '0;
        i_key_value   = '0;
        i_range_start = '0;
        i_range_end   = '0;
        i_child_key   = '0;
        i_child_depth = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_splits();
        test_random_runs(150);
        test_output_stall();
        test_back_to_back();
        test_random_runs(90);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (splitter_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && splitter_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: octree_child_range_splitter.f
rtl/core/ocrs_pkg.sv
rtl/core/ocrs_front.sv
rtl/core/ocrs_queue.sv
rtl/core/ocrs_back.sv
rtl/core/octree_child_range_splitter.sv
rtl/core/ocrs_checker.sv
dv/tb.sv
